FILE: hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_BITS_DEF    = 32;
	localparam int VALUE_BITS_DEF  = 32;

	localparam int         LIMIT_W     = 5;
	localparam logic [4:0] LIMIT_RESET = 5'd16;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SWEEP,
		ST_UPD
	} state_t;

	typedef enum logic [2:0] {
		UPD_NONE,
		UPD_GET_HIT,
		UPD_PUT_HIT,
		UPD_FILL,
		UPD_EVICT
	} upd_kind_t;

	typedef struct packed {
		logic      cmp_en;
		upd_kind_t kind;
	} cell_ctrl_t;

endpackage

FILE: hw/rtl/lkvc_cell.sv
module lkvc_cell #(
	parameter int IDX    = 0,
	parameter int KEY_W  = 32,
	parameter int VAL_W  = 32,
	parameter int RANK_W = 4,
	parameter int FILL_W = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lkvc_pkg::cell_ctrl_t  ctrl,
	input  logic [KEY_W-1:0]      req_key,
	input  logic [VAL_W-1:0]      req_value,
	input  logic [RANK_W-1:0]     hit_rank,
	input  logic [RANK_W-1:0]     lru_rank,
	input  logic [FILL_W-1:0]     fill,
	input  logic                  prev_hit,
	input  logic [VAL_W-1:0]      prev_value,
	input  logic [RANK_W-1:0]     prev_rank,
	output logic                  next_hit,
	output logic [VAL_W-1:0]      next_value,
	output logic [RANK_W-1:0]     next_rank
);
	import lkvc_pkg::*;

	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  value_q;
	logic [RANK_W-1:0] rank_q;
	logic              match_q;
	logic              next_hit_q;
	logic [VAL_W-1:0]  next_value_q;
	logic [RANK_W-1:0] next_rank_q;

	logic              occupied;
	logic              is_lru;
	logic              is_free_slot;
	logic [RANK_W-1:0] rank_inc;

	assign occupied     = fill > FILL_W'(IDX);
	assign is_lru       = occupied && (rank_q == lru_rank);
	assign is_free_slot = fill == FILL_W'(IDX);
	assign rank_inc     = RANK_W'(rank_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q    <= 1'b0;
			next_hit_q <= 1'b0;
		end else begin
			if (ctrl.cmp_en) begin
				match_q <= occupied && (key_q == req_key);
			end
			next_hit_q <= prev_hit | match_q;
		end
	end

	always_ff @(posedge clk) begin
		next_value_q <= match_q ? value_q : prev_value;
		next_rank_q  <= match_q ? rank_q : prev_rank;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
		end else begin
			unique case (ctrl.kind)
				UPD_GET_HIT, UPD_PUT_HIT: begin
					if (match_q) begin
						rank_q <= '0;
					end else if (occupied && rank_q < hit_rank) begin
						rank_q <= rank_inc;
					end
				end
				UPD_FILL: begin
					if (occupied) begin
						rank_q <= rank_inc;
					end else if (is_free_slot) begin
						rank_q <= '0;
					end
				end
				UPD_EVICT: begin
					if (is_lru) begin
						rank_q <= '0;
					end else if (occupied && rank_q < lru_rank) begin
						rank_q <= rank_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.kind)
			UPD_PUT_HIT: begin
				if (match_q) begin
					value_q <= req_value;
				end
			end
			UPD_FILL: begin
				if (is_free_slot) begin
					key_q   <= req_key;
					value_q <= req_value;
				end
			end
			UPD_EVICT: begin
				if (is_lru) begin
					key_q   <= req_key;
					value_q <= req_value;
				end
			end
			default: begin
			end
		endcase
	end

	assign next_hit   = next_hit_q;
	assign next_value = next_value_q;
	assign next_rank  = next_rank_q;

endmodule

FILE: hw/rtl/lru_key_value_cache_core.sv
// A get result is registered in the update state once the output is free.
// No new beat is taken until the current one leaves the update state. The
// match sweep walks the hit flag, value and rank down the chain of slot cells.
// Reset: asynchronous, active low; clears control, ranks and fill count and
// sets entry_limit to 16. Keys and values are not cleared; no clearing pass.
module lru_key_value_cache_core #(
	parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
	parameter int KEY_BITS    = lkvc_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lkvc_pkg::LIMIT_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic signed [KEY_BITS-1:0]    key,
	input  logic signed [VALUE_BITS-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic signed [VALUE_BITS-1:0]  read_value
);
	import lkvc_pkg::*;

	localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
	localparam int CNT_W  = RANK_W;
	localparam int CMP_W  = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

	state_t state_q, state_d;
	logic [CNT_W-1:0]      cnt_q;
	logic [LIMIT_W-1:0]    limit_q;
	logic [FILL_W-1:0]     fill_q;
	op_t                   op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  out_valid_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] read_value_q;

	cell_ctrl_t            ctrl;
	logic                  accept;
	logic                  out_free;
	logic                  load_out;
	logic [CMP_W-1:0]      lim_ext;
	logic [CMP_W-1:0]      eff_lim;
	logic                  can_fill;
	logic [RANK_W-1:0]     lru_rank;

	logic                  chain_hit   [0:MAX_ENTRIES];
	logic [VALUE_BITS-1:0] chain_value [0:MAX_ENTRIES];
	logic [RANK_W-1:0]     chain_rank  [0:MAX_ENTRIES];

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign lim_ext = CMP_W'(limit_q);
	always_comb begin
		if (lim_ext == '0) begin
			eff_lim = CMP_W'(1);
		end else if (lim_ext > CMP_W'(MAX_ENTRIES)) begin
			eff_lim = CMP_W'(MAX_ENTRIES);
		end else begin
			eff_lim = lim_ext;
		end
	end
	assign can_fill = CMP_W'(fill_q) < eff_lim;
	assign lru_rank = RANK_W'(fill_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == ST_SWEEP) ? CNT_W'(cnt_q + 1'b1) : '0;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctrl.cmp_en = 1'b0;
		ctrl.kind   = UPD_NONE;
		load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				ctrl.cmp_en = 1'b1;
				state_d     = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (cnt_q == CNT_W'(MAX_ENTRIES - 1)) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (op_q == OP_GET) begin
					if (out_free) begin
						load_out  = 1'b1;
						ctrl.kind = chain_hit[MAX_ENTRIES] ? UPD_GET_HIT : UPD_NONE;
						state_d   = ST_IDLE;
					end
				end else begin
					priority if (chain_hit[MAX_ENTRIES]) begin
						ctrl.kind = UPD_PUT_HIT;
					end else if (can_fill) begin
						ctrl.kind = UPD_FILL;
					end else begin
						ctrl.kind = UPD_EVICT;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (ctrl.kind == UPD_FILL) begin
				fill_q <= FILL_W'(fill_q + 1'b1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(opcode);
			key_q   <= key;
			value_q <= value;
		end
		if (load_out) begin
			hit_q        <= chain_hit[MAX_ENTRIES];
			read_value_q <= chain_hit[MAX_ENTRIES] ? chain_value[MAX_ENTRIES] : '1;
		end
	end

	assign chain_hit[0]   = 1'b0;
	assign chain_value[0] = '0;
	assign chain_rank[0]  = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		lkvc_cell #(
			.IDX    (i),
			.KEY_W  (KEY_BITS),
			.VAL_W  (VALUE_BITS),
			.RANK_W (RANK_W),
			.FILL_W (FILL_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.req_key    (key_q),
			.req_value  (value_q),
			.hit_rank   (chain_rank[MAX_ENTRIES]),
			.lru_rank   (lru_rank),
			.fill       (fill_q),
			.prev_hit   (chain_hit[i]),
			.prev_value (chain_value[i]),
			.prev_rank  (chain_rank[i]),
			.next_hit   (chain_hit[i+1]),
			.next_value (chain_value[i+1]),
			.next_rank  (chain_rank[i+1])
		);
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

endmodule

FILE: hw/rtl/lkvc_checker.sv
module lkvc_checker #(
	parameter int VALUE_BITS = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  hit,
	input logic [VALUE_BITS-1:0] read_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(read_value))
		else $error("stalled result beat changed");

	a_miss_ones: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> (&read_value))
		else $error("miss result not all ones");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("input not stalled while request in flight");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat without request in flight");

endmodule

bind lru_key_value_cache_core lkvc_checker #(
	.VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (.*);
